@@ hw/rtl/rbe_pkg.sv @@
// rbe_pkg: shared types, command and register codes, microcode table
// for the rigid body euler step block. no dependencies.
package rbe_pkg;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // command codes
  localparam logic [2:0] CMD_GRAVITY = 3'd0;
  localparam logic [2:0] CMD_FORCE   = 3'd1;
  localparam logic [2:0] CMD_TORQUE  = 3'd2;
  localparam logic [2:0] CMD_STEP    = 3'd3;
  localparam logic [2:0] CMD_SLEEP   = 3'd4;
  localparam logic [2:0] CMD_WAKE    = 3'd5;

  // register indexes
  localparam logic [2:0] REG_INV_MASS  = 3'd0;
  localparam logic [2:0] REG_INV_ROT   = 3'd1;
  localparam logic [2:0] REG_IS_STATIC = 3'd2;
  localparam logic [2:0] REG_TIME_STEP = 3'd3;
  localparam logic [2:0] REG_STILL_THR = 3'd4;
  localparam logic [2:0] REG_SLEEP_CNT = 3'd5;

  localparam logic [31:0] RST_INV_MASS  = 32'd65536;
  localparam logic [31:0] RST_INV_ROT   = 32'd65536;
  localparam logic [31:0] RST_TIME_STEP = 32'd1092;
  localparam logic [31:0] RST_STILL_THR = 32'd66;
  localparam logic [7:0]  RST_SLEEP_CNT = 8'd60;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_MUL,
    ST_WB,
    ST_DONE
  } state_t;

  // multiplier operand a
  typedef enum logic [3:0] {
    A_FX, A_FY, A_SA, A_TMP, A_VX, A_VY, A_W,
    A_INX, A_INY, A_INTQ, A_AX, A_AY
  } a_sel_t;

  // multiplier operand b
  typedef enum logic [2:0] {
    B_IMASS, B_IROT, B_DT, B_AX, B_AY
  } b_sel_t;

  // writeback target of a product
  typedef enum logic [3:0] {
    D_TMP, D_FX, D_FY, D_SA, D_VX, D_VY, D_PX, D_PY,
    D_W, D_ROT, D_SQ, D_STILL
  } dst_t;

  typedef struct packed {
    a_sel_t a_sel;
    b_sel_t b_sel;
    dst_t   dst;
    logic   last;
  } uop_t;

  typedef struct packed {
    logic        take;
    logic        begin_op;
    logic        mul;
    logic        wb;
    logic        finish;
    logic [2:0]  cmd;
    logic        active;
    uop_t        uop;
  } ctl_t;

  typedef struct packed {
    logic awake;
  } dp_sts_t;

  typedef struct packed {
    logic [31:0] inv_mass;
    logic [31:0] inv_rot;
    logic        is_static;
    logic [31:0] time_step;
    logic [31:0] still_thr;
    logic [7:0]  nap_limit;
  } cfg_t;

  // true when the command runs products through the multiplier
  function automatic logic has_uops(input logic [2:0] cmd, input logic active);
    logic r;
    r = 1'b0;
    unique case (cmd)
      CMD_FORCE, CMD_TORQUE: r = 1'b1;
      CMD_STEP, CMD_SLEEP:   r = active;
      default:               r = 1'b0;
    endcase
    return r;
  endfunction

  // product sequence of each command
  function automatic uop_t uop_lookup(input logic [2:0] cmd, input logic [3:0] idx);
    uop_t u;
    u = '{a_sel: A_FX, b_sel: B_IMASS, dst: D_TMP, last: 1'b1};
    unique case (cmd)
      CMD_FORCE: begin
        if (idx == 4'd0) u = '{a_sel: A_INX, b_sel: B_IMASS, dst: D_FX, last: 1'b0};
        else             u = '{a_sel: A_INY, b_sel: B_IMASS, dst: D_FY, last: 1'b1};
      end
      CMD_TORQUE: u = '{a_sel: A_INTQ, b_sel: B_IMASS, dst: D_SA, last: 1'b1};
      CMD_STEP: begin
        unique case (idx)
          4'd0:    u = '{a_sel: A_FX,  b_sel: B_IMASS, dst: D_TMP, last: 1'b0};
          4'd1:    u = '{a_sel: A_TMP, b_sel: B_DT,    dst: D_VX,  last: 1'b0};
          4'd2:    u = '{a_sel: A_VX,  b_sel: B_DT,    dst: D_PX,  last: 1'b0};
          4'd3:    u = '{a_sel: A_FY,  b_sel: B_IMASS, dst: D_TMP, last: 1'b0};
          4'd4:    u = '{a_sel: A_TMP, b_sel: B_DT,    dst: D_VY,  last: 1'b0};
          4'd5:    u = '{a_sel: A_VY,  b_sel: B_DT,    dst: D_PY,  last: 1'b0};
          4'd6:    u = '{a_sel: A_SA,  b_sel: B_IROT,  dst: D_TMP, last: 1'b0};
          4'd7:    u = '{a_sel: A_TMP, b_sel: B_DT,    dst: D_W,   last: 1'b0};
          default: u = '{a_sel: A_W,   b_sel: B_DT,    dst: D_ROT, last: 1'b1};
        endcase
      end
      CMD_SLEEP: begin
        if (idx == 4'd0) u = '{a_sel: A_AX, b_sel: B_AX, dst: D_SQ,    last: 1'b0};
        else             u = '{a_sel: A_AY, b_sel: B_AY, dst: D_STILL, last: 1'b1};
      end
      default: u = '{a_sel: A_FX, b_sel: B_IMASS, dst: D_TMP, last: 1'b1};
    endcase
    return u;
  endfunction

endpackage

@@ hw/rtl/rbe_ctrl.sv @@
// rbe_ctrl: sequencer for the rigid body block, walks the product list of a
// command and owns the result valid flag. depends on rbe_pkg.
module rbe_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [2:0]      in_command,
  output logic            out_valid,
  input  logic            out_ready,
  input  logic            is_static,
  input  rbe_pkg::dp_sts_t sts,
  output rbe_pkg::ctl_t   ctl
);

  rbe_pkg::state_t st_r, st_nxt;
  logic [3:0] idx_r;
  logic [2:0] cmd_r;
  logic       active_r;
  logic       out_valid_r;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      rbe_pkg::ST_IDLE:  if (in_valid) st_nxt = rbe_pkg::ST_START;
      rbe_pkg::ST_START: st_nxt = rbe_pkg::has_uops(cmd_r, active_r) ?
                                  rbe_pkg::ST_MUL : rbe_pkg::ST_DONE;
      rbe_pkg::ST_MUL:   st_nxt = rbe_pkg::ST_WB;
      rbe_pkg::ST_WB:    st_nxt = ctl.uop.last ? rbe_pkg::ST_DONE : rbe_pkg::ST_MUL;
      rbe_pkg::ST_DONE:  if (slot_free) st_nxt = rbe_pkg::ST_IDLE;
      default:           st_nxt = rbe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = (st_r == rbe_pkg::ST_IDLE);
    ctl.take     = (st_r == rbe_pkg::ST_IDLE) && in_valid;
    ctl.begin_op = (st_r == rbe_pkg::ST_START);
    ctl.mul      = (st_r == rbe_pkg::ST_MUL);
    ctl.wb       = (st_r == rbe_pkg::ST_WB);
    ctl.finish   = (st_r == rbe_pkg::ST_DONE) && slot_free;
    ctl.cmd      = cmd_r;
    ctl.active   = active_r;
    ctl.uop      = rbe_pkg::uop_lookup(cmd_r, idx_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= rbe_pkg::ST_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (ctl.begin_op) idx_r <= '0;
      else if (ctl.wb) idx_r <= idx_r + 4'd1;
      if (ctl.finish) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // command and gating latched at transfer
  always_ff @(posedge clk) begin
    if (ctl.take) begin
      cmd_r    <= in_command;
      active_r <= sts.awake && !is_static;
    end
  end

  a_take_start: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.take |=> st_r == rbe_pkg::ST_START)
    else $error("accepted item did not start");

  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.wb && ctl.uop.last |=> st_r == rbe_pkg::ST_DONE)
    else $error("sequence ran past its last product");

  a_hold_done: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == rbe_pkg::ST_DONE && !slot_free |=> st_r == rbe_pkg::ST_DONE && out_valid_r)
    else $error("result dropped while output slot busy");

endmodule

@@ hw/rtl/rbe_dp.sv @@
// rbe_dp: body state, shared 33x33 multiplier with product register,
// saturating writeback and result registers. depends on rbe_pkg.
module rbe_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  rbe_pkg::ctl_t     ctl,
  input  rbe_pkg::cfg_t     cfg,
  input  logic [31:0]       in_vec_x,
  input  logic [31:0]       in_vec_y,
  input  logic [31:0]       in_torque,
  output rbe_pkg::dp_sts_t  sts,
  output logic [31:0]       out_pos_x,
  output logic [31:0]       out_pos_y,
  output logic [31:0]       out_angle,
  output logic              out_awake
);

  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  logic signed [31:0] px_r, py_r, prevx_r, prevy_r, vx_r, vy_r;
  logic signed [31:0] fx_r, fy_r, rot_r, w_r, sa_r, tmp_r;
  logic signed [31:0] in_x_r, in_y_r, in_tq_r;
  logic               awake_r;
  logic [7:0]         cnt_r;
  logic signed [65:0] prod_r;
  logic [48:0]        sq_r;
  logic [31:0]        opx_r, opy_r, oang_r;
  logic               oawake_r;

  logic signed [32:0] a_op, b_op;
  logic signed [32:0] dx, dy;
  logic [32:0]        ax, ay;
  logic               big;
  logic signed [31:0] q;
  logic [49:0]        sq_total, sq_limit;
  logic               still;
  logic [7:0]         cnt_inc;

  // floor shift by 16 then clamp to 32 bits
  function automatic logic signed [31:0] qsat(input logic signed [65:0] p);
    logic [49:0] s;
    logic signed [31:0] r;
    s = p[65:16];
    if (s[49:31] == '0 || s[49:31] == '1) r = s[31:0];
    else r = s[49] ? S32_MIN : S32_MAX;
    return r;
  endfunction

  function automatic logic signed [31:0] sadd(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [32:0] s;
    logic signed [31:0] r;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) r = s[32] ? S32_MIN : S32_MAX;
    else r = s[31:0];
    return r;
  endfunction

  // movement since the last check, taken exactly
  assign dx  = {px_r[31], px_r} - {prevx_r[31], prevx_r};
  assign dy  = {py_r[31], py_r} - {prevy_r[31], prevy_r};
  assign ax  = dx[32] ? 33'(-dx) : dx;
  assign ay  = dy[32] ? 33'(-dy) : dy;
  assign big = (|ax[32:24]) || (|ay[32:24]);

  always_comb begin
    case (ctl.uop.a_sel)
      rbe_pkg::A_FX:   a_op = {fx_r[31], fx_r};
      rbe_pkg::A_FY:   a_op = {fy_r[31], fy_r};
      rbe_pkg::A_SA:   a_op = {sa_r[31], sa_r};
      rbe_pkg::A_TMP:  a_op = {tmp_r[31], tmp_r};
      rbe_pkg::A_VX:   a_op = {vx_r[31], vx_r};
      rbe_pkg::A_VY:   a_op = {vy_r[31], vy_r};
      rbe_pkg::A_W:    a_op = {w_r[31], w_r};
      rbe_pkg::A_INX:  a_op = {in_x_r[31], in_x_r};
      rbe_pkg::A_INY:  a_op = {in_y_r[31], in_y_r};
      rbe_pkg::A_INTQ: a_op = {in_tq_r[31], in_tq_r};
      rbe_pkg::A_AX:   a_op = {9'd0, ax[23:0]};
      rbe_pkg::A_AY:   a_op = {9'd0, ay[23:0]};
      default:         a_op = '0;
    endcase
    case (ctl.uop.b_sel)
      rbe_pkg::B_IMASS: b_op = {1'b0, cfg.inv_mass};
      rbe_pkg::B_IROT:  b_op = {1'b0, cfg.inv_rot};
      rbe_pkg::B_DT:    b_op = {1'b0, cfg.time_step};
      rbe_pkg::B_AX:    b_op = {9'd0, ax[23:0]};
      rbe_pkg::B_AY:    b_op = {9'd0, ay[23:0]};
      default:          b_op = '0;
    endcase
  end

  assign q        = qsat(prod_r);
  assign sq_total = {1'b0, sq_r} + {1'b0, prod_r[48:0]};
  assign sq_limit = {2'd0, cfg.still_thr, 16'd0};
  assign still    = !big && (sq_total < sq_limit);
  assign cnt_inc  = (still && cnt_r != 8'hFF) ? cnt_r + 8'd1 : cnt_r;

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      in_x_r  <= in_vec_x;
      in_y_r  <= in_vec_y;
      in_tq_r <= in_torque;
    end
    if (ctl.mul) prod_r <= a_op * b_op;
    if (ctl.wb && ctl.uop.dst == rbe_pkg::D_SQ) sq_r <= prod_r[48:0];
    if (ctl.wb && ctl.uop.dst == rbe_pkg::D_TMP) tmp_r <= q;
    if (ctl.finish) begin
      opx_r    <= px_r;
      opy_r    <= py_r;
      oang_r   <= rot_r;
      oawake_r <= awake_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r    <= '0; py_r    <= '0; prevx_r <= '0; prevy_r <= '0;
      vx_r    <= '0; vy_r    <= '0; fx_r    <= '0; fy_r    <= '0;
      rot_r   <= '0; w_r     <= '0; sa_r    <= '0;
      awake_r <= 1'b1;
      cnt_r   <= '0;
    end else if (ctl.begin_op) begin
      case (ctl.cmd)
        rbe_pkg::CMD_GRAVITY: begin
          if (awake_r) begin
            vx_r <= sadd(vx_r, in_x_r);
            vy_r <= sadd(vy_r, in_y_r);
          end
        end
        rbe_pkg::CMD_FORCE, rbe_pkg::CMD_TORQUE, rbe_pkg::CMD_WAKE: begin
          awake_r <= 1'b1;
          cnt_r   <= '0;
        end
        rbe_pkg::CMD_STEP: begin
          if (ctl.active) begin
            prevx_r <= px_r;
            prevy_r <= py_r;
          end
        end
        default: ;
      endcase
    end else if (ctl.wb) begin
      case (ctl.uop.dst)
        rbe_pkg::D_FX:  fx_r  <= sadd(fx_r, q);
        rbe_pkg::D_FY:  fy_r  <= sadd(fy_r, q);
        rbe_pkg::D_SA:  sa_r  <= sadd(sa_r, q);
        rbe_pkg::D_VX:  vx_r  <= sadd(vx_r, q);
        rbe_pkg::D_VY:  vy_r  <= sadd(vy_r, q);
        rbe_pkg::D_PX:  px_r  <= sadd(px_r, q);
        rbe_pkg::D_PY:  py_r  <= sadd(py_r, q);
        rbe_pkg::D_W:   w_r   <= sadd(w_r, q);
        rbe_pkg::D_ROT: rot_r <= sadd(rot_r, q);
        rbe_pkg::D_STILL: begin
          cnt_r <= cnt_inc;
          if (cnt_inc >= cfg.nap_limit) awake_r <= 1'b0;
          prevx_r <= px_r;
          prevy_r <= py_r;
        end
        default: ;
      endcase
    end else if (ctl.finish && ctl.cmd == rbe_pkg::CMD_STEP && ctl.active) begin
      fx_r <= '0;
      fy_r <= '0;
      sa_r <= '0;
    end
  end

  assign sts.awake = awake_r;
  assign out_pos_x = opx_r;
  assign out_pos_y = opy_r;
  assign out_angle = oang_r;
  assign out_awake = oawake_r;

  a_step_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.finish && ctl.cmd == rbe_pkg::CMD_STEP && ctl.active
    |=> fx_r == '0 && fy_r == '0 && sa_r == '0)
    else $error("accumulators not cleared after step");

  a_wake: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.begin_op && (ctl.cmd == rbe_pkg::CMD_FORCE || ctl.cmd == rbe_pkg::CMD_TORQUE ||
                     ctl.cmd == rbe_pkg::CMD_WAKE)
    |=> awake_r && cnt_r == '0)
    else $error("wake command left body asleep");

  a_step_prev: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.begin_op && ctl.cmd == rbe_pkg::CMD_STEP && ctl.active
    |=> prevx_r == $past(px_r) && prevy_r == $past(py_r))
    else $error("previous position not captured at step start");

endmodule

@@ hw/rtl/rigid_body_euler_step.sv @@
// rigid_body_euler_step: top level, register file on the apb-style port,
// sequencer and datapath. depends on rbe_pkg, rbe_ctrl, rbe_dp.
//
//   channel   handshake                fields
//   in        in_valid / in_ready      in_command in_vec_x in_vec_y in_torque
//   out       out_valid / out_ready    out_pos_x out_pos_y out_angle out_awake
//   cfg       psel penable pwrite      paddr pwdata prdata (pready tied high)
//
// an item runs through a start step, then, for each product it needs on the
// single shared multiplier, a multiply into the product register followed by
// a saturate and write back, then a done step that holds until the result
// register is free. a skipped step or sleep check, and every command without
// products, goes straight from the start step to the done step.
// in_ready is high only while no item is in progress; the result register
// frees the input side, a second result waits until the first is taken.
// synchronous reset loads the register defaults, zeroes the body and wakes it.
module rigid_body_euler_step (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [2:0]                 in_command,
  input  logic signed [31:0]         in_vec_x,
  input  logic signed [31:0]         in_vec_y,
  input  logic signed [31:0]         in_torque,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [31:0]         out_pos_x,
  output logic signed [31:0]         out_pos_y,
  output logic signed [31:0]         out_angle,
  output logic                       out_awake,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rbe_pkg::ADDR_W-1:0] paddr,
  input  logic [rbe_pkg::DATA_W-1:0] pwdata,
  output logic [rbe_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  rbe_pkg::cfg_t    cfg_r;
  rbe_pkg::ctl_t    ctl;
  rbe_pkg::dp_sts_t sts;
  logic             cfg_wr;
  logic [2:0]       cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inv_mass  <= rbe_pkg::RST_INV_MASS;
      cfg_r.inv_rot   <= rbe_pkg::RST_INV_ROT;
      cfg_r.is_static <= 1'b0;
      cfg_r.time_step <= rbe_pkg::RST_TIME_STEP;
      cfg_r.still_thr <= rbe_pkg::RST_STILL_THR;
      cfg_r.nap_limit <= rbe_pkg::RST_SLEEP_CNT;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        rbe_pkg::REG_INV_MASS:  cfg_r.inv_mass  <= pwdata;
        rbe_pkg::REG_INV_ROT:   cfg_r.inv_rot   <= pwdata;
        rbe_pkg::REG_IS_STATIC: cfg_r.is_static <= pwdata[0];
        rbe_pkg::REG_TIME_STEP: cfg_r.time_step <= pwdata;
        rbe_pkg::REG_STILL_THR: cfg_r.still_thr <= pwdata;
        rbe_pkg::REG_SLEEP_CNT: cfg_r.nap_limit <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      rbe_pkg::REG_INV_MASS:  prdata = cfg_r.inv_mass;
      rbe_pkg::REG_INV_ROT:   prdata = cfg_r.inv_rot;
      rbe_pkg::REG_IS_STATIC: prdata = {31'd0, cfg_r.is_static};
      rbe_pkg::REG_TIME_STEP: prdata = cfg_r.time_step;
      rbe_pkg::REG_STILL_THR: prdata = cfg_r.still_thr;
      rbe_pkg::REG_SLEEP_CNT: prdata = {24'd0, cfg_r.nap_limit};
      default:                prdata = '0;
    endcase
  end

  rbe_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .is_static  (cfg_r.is_static),
    .sts        (sts),
    .ctl        (ctl)
  );

  rbe_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .cfg       (cfg_r),
    .in_vec_x  (in_vec_x),
    .in_vec_y  (in_vec_y),
    .in_torque (in_torque),
    .sts       (sts),
    .out_pos_x (out_pos_x),
    .out_pos_y (out_pos_y),
    .out_angle (out_angle),
    .out_awake (out_awake)
  );

endmodule

@@ tb/rbe_pose_checker.sv @@
// rbe_pose_checker: watches the command, result and register ports of
// rigid_body_euler_step, predicts each pose and compares. depends on rbe_pkg.
module rbe_pose_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [2:0]                 in_command,
  input  logic signed [31:0]         in_vec_x,
  input  logic signed [31:0]         in_vec_y,
  input  logic signed [31:0]         in_torque,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic signed [31:0]         out_pos_x,
  input  logic signed [31:0]         out_pos_y,
  input  logic signed [31:0]         out_angle,
  input  logic                       out_awake,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [rbe_pkg::ADDR_W-1:0] paddr,
  input  logic [rbe_pkg::DATA_W-1:0] pwdata,
  output int                         errors,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] angle;
    logic               awake;
  } pose_t;

  pose_t pose_q[$];
  int    fail_total = 0;
  int    waiting_n = 0;

  assign errors  = fail_total;
  assign pending = waiting_n;

  // register copy
  logic [31:0] m_inv, i_inv, dt, still_lim;
  logic        static_body;
  logic [7:0]  nap_count;

  // body state
  logic signed [31:0] body_px, body_py, prev_px, prev_py;
  logic signed [31:0] vel_x, vel_y, push_x, push_y;
  logic signed [31:0] turn, spin, spin_acc;
  logic               awake_st;
  logic [7:0]         still_cnt;

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > longint'(32'sh7fffffff)) return 32'sh7fffffff;
    if (v < -longint'(64'h80000000)) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] add_sat(logic signed [31:0] a, logic signed [31:0] b);
    return clamp32(longint'(a) + longint'(b));
  endfunction

  // q16.16 product, floor of the exact product then clamped
  function automatic logic signed [31:0] q_mul(longint a, longint b);
    longint p;
    p = a * b;
    return clamp32(p >>> 16);
  endfunction

  function automatic void reset_body();
    m_inv = rbe_pkg::RST_INV_MASS;
    i_inv = rbe_pkg::RST_INV_ROT;
    static_body = 1'b0;
    dt = rbe_pkg::RST_TIME_STEP;
    still_lim = rbe_pkg::RST_STILL_THR;
    nap_count = rbe_pkg::RST_SLEEP_CNT;
    body_px = '0; body_py = '0; prev_px = '0; prev_py = '0;
    vel_x = '0; vel_y = '0; push_x = '0; push_y = '0;
    turn = '0; spin = '0; spin_acc = '0;
    awake_st = 1'b1;
    still_cnt = '0;
  endfunction

  function automatic void write_setting(logic [rbe_pkg::ADDR_W-1:0] addr, logic [31:0] data);
    case (addr[4:2])
      rbe_pkg::REG_INV_MASS:  m_inv = data;
      rbe_pkg::REG_INV_ROT:   i_inv = data;
      rbe_pkg::REG_IS_STATIC: static_body = data[0];
      rbe_pkg::REG_TIME_STEP: dt = data;
      rbe_pkg::REG_STILL_THR: still_lim = data;
      rbe_pkg::REG_SLEEP_CNT: nap_count = data[7:0];
      default: ;
    endcase
  endfunction

  function automatic logic body_is_still();
    longint ax, ay;
    ax = longint'(body_px) - longint'(prev_px);
    ay = longint'(body_py) - longint'(prev_py);
    if (ax < 0) ax = -ax;
    if (ay < 0) ay = -ay;
    // beyond 2^24 the square already exceeds any threshold
    if (ax >= 64'sd16777216 || ay >= 64'sd16777216) return 1'b0;
    return (ax * ax + ay * ay) < (longint'(still_lim) << 16);
  endfunction

  function automatic pose_t integrate_command(logic [2:0] cmd, logic signed [31:0] vx,
                                              logic signed [31:0] vy, logic signed [31:0] tq);
    pose_t r;
    case (cmd)
      rbe_pkg::CMD_GRAVITY: begin
        if (awake_st) begin
          vel_x = add_sat(vel_x, vx);
          vel_y = add_sat(vel_y, vy);
        end
      end
      rbe_pkg::CMD_FORCE: begin
        awake_st = 1'b1;
        still_cnt = '0;
        push_x = add_sat(push_x, q_mul(vx, longint'(m_inv)));
        push_y = add_sat(push_y, q_mul(vy, longint'(m_inv)));
      end
      rbe_pkg::CMD_TORQUE: begin
        awake_st = 1'b1;
        still_cnt = '0;
        spin_acc = add_sat(spin_acc, q_mul(tq, longint'(m_inv)));
      end
      rbe_pkg::CMD_STEP: begin
        if (awake_st && !static_body) begin
          prev_px = body_px;
          prev_py = body_py;
          vel_x = add_sat(vel_x, q_mul(q_mul(push_x, longint'(m_inv)), longint'(dt)));
          vel_y = add_sat(vel_y, q_mul(q_mul(push_y, longint'(m_inv)), longint'(dt)));
          body_px = add_sat(body_px, q_mul(vel_x, longint'(dt)));
          body_py = add_sat(body_py, q_mul(vel_y, longint'(dt)));
          spin = add_sat(spin, q_mul(q_mul(spin_acc, longint'(i_inv)), longint'(dt)));
          turn = add_sat(turn, q_mul(spin, longint'(dt)));
          push_x = '0;
          push_y = '0;
          spin_acc = '0;
        end
      end
      rbe_pkg::CMD_SLEEP: begin
        if (awake_st && !static_body) begin
          if (body_is_still() && still_cnt != 8'hff) still_cnt++;
          if (still_cnt >= nap_count) awake_st = 1'b0;
          prev_px = body_px;
          prev_py = body_py;
        end
      end
      rbe_pkg::CMD_WAKE: begin
        awake_st = 1'b1;
        still_cnt = '0;
      end
      default: ;
    endcase
    r.pos_x = body_px;
    r.pos_y = body_py;
    r.angle = turn;
    r.awake = awake_st;
    return r;
  endfunction

  function automatic int check_field(string name, logic signed [31:0] want,
                                     logic signed [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  initial reset_body();

  always @(posedge clk) begin : watch
    pose_t want;
    int    bad;
    bad = 0;
    if (!rst_n) begin
      reset_body();
      pose_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pose_q.size() == 0) begin
          $error("result transfer with no command outstanding");
          bad++;
        end else begin
          want = pose_q.pop_front();
          bad += check_field("pos_x", want.pos_x, out_pos_x);
          bad += check_field("pos_y", want.pos_y, out_pos_y);
          bad += check_field("angle", want.angle, out_angle);
          bad += check_field("awake", {31'b0, want.awake}, {31'b0, out_awake});
        end
      end
      if (psel && penable && pwrite && pready) write_setting(paddr, pwdata);
      if (in_valid && in_ready)
        pose_q.push_back(integrate_command(in_command, in_vec_x, in_vec_y, in_torque));
    end
    fail_total <= fail_total + bad;
    waiting_n <= pose_q.size();
  end

endmodule

@@ tb/rigid_body_euler_step_test.sv @@
// rigid_body_euler_step_test: drives commands and register writes into
// rigid_body_euler_step and reports the verdict. depends on rbe_pkg, rbe_pose_checker.
module rigid_body_euler_step_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CMD_UNUSED_A = 3'd6;
  localparam logic [2:0] CMD_UNUSED_B = 3'd7;
  localparam logic [2:0] REG_SPARE_A  = 3'd6;
  localparam logic [2:0] REG_SPARE_B  = 3'd7;
  localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 105;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [2:0]                  in_command = rbe_pkg::CMD_GRAVITY;
  logic signed [31:0]          in_vec_x = '0;
  logic signed [31:0]          in_vec_y = '0;
  logic signed [31:0]          in_torque = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic signed [31:0]          out_pos_x, out_pos_y, out_angle;
  logic                        out_awake;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [rbe_pkg::ADDR_W-1:0]  paddr = '0;
  logic [rbe_pkg::DATA_W-1:0]  pwdata = '0;
  logic [rbe_pkg::DATA_W-1:0]  prdata;
  logic                        pready;

  int   errors, pending;
  logic steady = 1'b0;
  int   items_sent = 0;
  int   phase_start;
  int   p;

  rigid_body_euler_step DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_vec_x(in_vec_x), .in_vec_y(in_vec_y), .in_torque(in_torque),
    .out_valid(out_valid), .out_ready(out_ready), .out_pos_x(out_pos_x),
    .out_pos_y(out_pos_y), .out_angle(out_angle), .out_awake(out_awake),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  rbe_pose_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_vec_x(in_vec_x), .in_vec_y(in_vec_y), .in_torque(in_torque),
    .out_valid(out_valid), .out_ready(out_ready), .out_pos_x(out_pos_x),
    .out_pos_y(out_pos_y), .out_angle(out_angle), .out_awake(out_awake),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .errors(errors), .pending(pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("FAIL");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 37);
  end

  // mostly small values so the body stays in range, some full-scale and corners
  function automatic logic signed [31:0] rand_q();
    logic signed [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = int'($urandom_range(0, 524288)) - 262144;
      4, 5:       v = int'($urandom_range(0, 33554432)) - 16777216;
      6, 7:       v = $urandom;
      8: begin
        case ($urandom_range(0, 3))
          0:       v = Q_MAX;
          1:       v = Q_MIN;
          2:       v = '0;
          default: v = -1;
        endcase
      end
      default:    v = int'($urandom_range(0, 131072)) - 65536;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rand_scale(int unsigned cap);
    if ($urandom_range(0, 4) == 0) return $urandom;
    return $urandom_range(0, cap);
  endfunction

  task automatic send_item(logic [2:0] cmd, logic signed [31:0] x, logic signed [31:0] y,
                           logic signed [31:0] t);
    if (!steady) begin
      while ($urandom_range(0, 99) < 37) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_vec_x   <= x;
    in_vec_y   <= y;
    in_torque  <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_rand(logic [2:0] cmd);
    send_item(cmd, rand_q(), rand_q(), rand_q());
  endtask

  // hold off new commands until every pose has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
  endtask

  task automatic load_settings(logic [31:0] im, logic [31:0] ir, logic st, logic [31:0] step_dt,
                               logic [31:0] thr, logic [7:0] nap);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(rbe_pkg::REG_INV_MASS, im);
    write_reg(rbe_pkg::REG_INV_ROT, ir);
    // narrow registers get random upper bits, which must be dropped
    write_reg(rbe_pkg::REG_IS_STATIC, {junk[31:1], st});
    write_reg(rbe_pkg::REG_TIME_STEP, step_dt);
    write_reg(rbe_pkg::REG_STILL_THR, thr);
    write_reg(rbe_pkg::REG_SLEEP_CNT, {junk[23:0], nap});
    write_reg(REG_SPARE_A, $urandom);
    write_reg(REG_SPARE_B, $urandom);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic run_burst();
    logic [2:0] push_cmds [3];
    int kind, n;
    push_cmds = '{rbe_pkg::CMD_GRAVITY, rbe_pkg::CMD_FORCE, rbe_pkg::CMD_TORQUE};
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      // a physics tick: some pushes, a step, often a sleep check
      n = $urandom_range(0, 3);
      repeat (n) send_rand(push_cmds[$urandom_range(0, 2)]);
      send_rand(rbe_pkg::CMD_STEP);
      if ($urandom_range(0, 1) == 1) send_rand(rbe_pkg::CMD_SLEEP);
    end else if (kind < 8) begin
      // let the body settle, then poke it while it may be asleep
      n = $urandom_range(1, 8);
      repeat (n) send_rand(rbe_pkg::CMD_SLEEP);
      send_rand(rbe_pkg::CMD_GRAVITY);
      send_rand(rbe_pkg::CMD_STEP);
      if ($urandom_range(0, 1) == 1) send_rand(rbe_pkg::CMD_WAKE);
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) send_rand(3'($urandom_range(0, 7)));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corners at reset settings
    send_item(rbe_pkg::CMD_STEP, '0, '0, '0);
    send_item(rbe_pkg::CMD_GRAVITY, Q_MAX, Q_MIN, -1);
    send_item(rbe_pkg::CMD_GRAVITY, Q_MAX, Q_MIN, '0);
    send_item(rbe_pkg::CMD_STEP, -1, -1, -1);
    send_item(rbe_pkg::CMD_SLEEP, '0, '0, '0);
    send_item(rbe_pkg::CMD_GRAVITY, Q_MIN, Q_MAX, '0);
    send_item(rbe_pkg::CMD_FORCE, Q_MAX, Q_MIN, '0);
    send_item(rbe_pkg::CMD_FORCE, -1, 32'sd1, '0);
    send_item(rbe_pkg::CMD_TORQUE, '0, '0, Q_MAX);
    send_item(rbe_pkg::CMD_TORQUE, '0, '0, Q_MIN);
    send_item(rbe_pkg::CMD_TORQUE, '0, '0, Q_MIN);
    send_item(rbe_pkg::CMD_STEP, '0, '0, '0);
    send_item(rbe_pkg::CMD_WAKE, -1, -1, -1);
    send_item(CMD_UNUSED_A, Q_MAX, Q_MAX, Q_MAX);
    send_item(CMD_UNUSED_B, Q_MIN, Q_MIN, Q_MIN);
    send_item(rbe_pkg::CMD_SLEEP, '0, '0, '0);
    send_item(rbe_pkg::CMD_SLEEP, '0, '0, '0);

    for (p = 1; p <= PHASES; p++) begin
      drain();
      steady <= (p == 1);
      case (p)
        1: load_settings(rbe_pkg::RST_INV_MASS, rbe_pkg::RST_INV_ROT, 1'b0,
                         rbe_pkg::RST_TIME_STEP, rbe_pkg::RST_STILL_THR, 8'd3);
        2: load_settings('0, '0, 1'b0, '0, '0, 8'd0);
        3: load_settings('1, '1, 1'b0, '1, '1, 8'hff);
        4: load_settings(rand_scale(32'h40000), rand_scale(32'h40000), 1'b1,
                         rbe_pkg::RST_TIME_STEP, rbe_pkg::RST_STILL_THR, 8'd2);
        default: load_settings(rand_scale(32'h40000), rand_scale(32'h40000),
                               $urandom_range(0, 3) == 0, rand_scale(32'h4000),
                               rand_scale(32'h100000),
                               ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 6))
                                                           : 8'($urandom));
      endcase
      phase_start = items_sent;
      if (p == 3) begin
        // long run of still checks drives the counter to its ceiling
        send_rand(rbe_pkg::CMD_WAKE);
        repeat (256) send_rand(rbe_pkg::CMD_SLEEP);
        phase_start = items_sent;
      end
      while (items_sent - phase_start < PHASE_ITEMS) run_burst();
    end

    drain();
    repeat (24) @(posedge clk);
    $display("covered %0d commands over %0d register settings: reset values, all-zero,",
             items_sent, PHASES + 1);
    $display("full-scale, a static body and random scales, with sleep and wake cycles");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
